/* src/mfp_pkg.sv */
// Shared types, constants and the CRC-8/Maxim byte update for the motor
// feedback frame parser. No dependencies.
`default_nettype none

package mfp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 4;

  localparam logic [CountW-1:0] FrameLen = 4'd10;  // bytes in a good frame
  localparam logic [CountW-1:0] CrcSpan  = 4'd9;   // bytes 0..8 enter the CRC
  localparam logic [CountW-1:0] CountSat = 4'd11;  // "more than ten"
  localparam logic [ByteW-1:0]  CrcPoly  = 8'h8C;  // reflected 0x31
  localparam logic [ByteW-1:0]  CrcInit  = 8'h00;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_BAD_LEN      = 2'd1,
    ST_ID_MISMATCH  = 2'd2,
    ST_CRC_MISMATCH = 2'd3
  } status_e;

  typedef struct packed {
    status_e            status;
    logic [ByteW-1:0]   drive_mode;
    logic signed [15:0] torque_current;
    logic signed [15:0] shaft_speed;
    logic [15:0]        shaft_position;
    logic [ByteW-1:0]   fault;
  } result_t;

  // LSB-first CRC-8/Maxim, one byte
  function automatic logic [ByteW-1:0] crc_update(input logic [ByteW-1:0] crc,
                                                  input logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* src/motor_feedback_frame_parser_unit.sv */
// Motor feedback frame parser: byte counter, running CRC-8/Maxim, field
// capture and frame checks. Depends on mfp_pkg and mfp_out_buf.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one frame byte per beat,
//   frame_end_i set on the last byte. Output channel (out_valid_o /
//   out_stall_i) carries one result per frame: status plus decoded fields,
//   fields zero unless status is ok.
//   A byte is taken every cycle while in_stall_o is low. The result of a
//   frame is registered when its last byte is accepted; the CRC update is an
//   8-step unrolled xor network evaluated in the accepting cycle.
//   The output holds a result register and one skid entry, so bytes keep
//   flowing while a result waits; in_stall_o goes high only once both are
//   occupied, i.e. after the receiver has stalled a result and another
//   frame has finished behind it. Reset clears the byte count, the CRC and
//   expected_id, and drops any pending result. The user must write
//   expected_id with expected_id_we_i only while idle; the block does not enforce it.
`default_nettype none

module motor_feedback_frame_parser_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        expected_id_we_i,
  input  wire logic [7:0]  expected_id_i,
  // byte input
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        frame_end_i,
  // result output
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [7:0]       drive_mode_o,
  output logic signed [15:0] torque_current_o,
  output logic signed [15:0] shaft_speed_o,
  output logic [15:0]      shaft_position_o,
  output logic [7:0]       fault_o
);
  import mfp_pkg::*;

  logic [ByteW-1:0]  expected_id_q;
  logic [CountW-1:0] byte_count_q, byte_count_d;
  logic [ByteW-1:0]  crc_q, crc_d;
  logic [ByteW-1:0]  id_seen_q;
  logic [ByteW-1:0]  payload_q [8];

  logic              accept;
  logic [CountW-1:0] count_inc;
  logic [2:0]        pay_idx;
  status_e           status;
  result_t           res;
  result_t           out_data;
  logic              buf_full;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i & ~buf_full;
  assign count_inc  = (byte_count_q < CountSat) ? byte_count_q + 4'd1 : byte_count_q;
  assign pay_idx    = 3'(byte_count_q - 4'd1);

  always_comb begin
    byte_count_d = byte_count_q;
    crc_d        = crc_q;
    if (accept) begin
      if (frame_end_i) begin
        byte_count_d = '0;
        crc_d        = CrcInit;
      end else begin
        byte_count_d = count_inc;
        if (byte_count_q < CrcSpan) begin
          crc_d = crc_update(crc_q, rx_byte_i);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_id_q <= '0;
      byte_count_q  <= '0;
      crc_q         <= CrcInit;
    end else begin
      if (expected_id_we_i) begin
        expected_id_q <= expected_id_i;
      end
      byte_count_q <= byte_count_d;
      crc_q        <= crc_d;
    end
  end

  // captured bytes; only read on a full-length frame, which rewrites them all
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (byte_count_q == '0) begin
        id_seen_q <= rx_byte_i;
      end else if (byte_count_q < CrcSpan) begin
        payload_q[pay_idx] <= rx_byte_i;
      end
    end
  end

  // the check byte is the current byte on a well-formed last beat
  always_comb begin
    if (count_inc != FrameLen) begin
      status = ST_BAD_LEN;
    end else if (id_seen_q != expected_id_q) begin
      status = ST_ID_MISMATCH;
    end else if (crc_q != rx_byte_i) begin
      status = ST_CRC_MISMATCH;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    res        = '0;
    res.status = status;
    if (status == ST_OK) begin
      res.drive_mode     = payload_q[0];
      res.torque_current = {payload_q[1], payload_q[2]};
      res.shaft_speed    = {payload_q[3], payload_q[4]};
      res.shaft_position = {payload_q[5], payload_q[6]};
      res.fault          = payload_q[7];
    end
  end

  mfp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept & frame_end_i),
    .push_data_i (res),
    .full_o      (buf_full),
    .valid_o     (out_valid_o),
    .stall_i     (out_stall_i),
    .data_o      (out_data)
  );

  assign status_o         = out_data.status;
  assign drive_mode_o     = out_data.drive_mode;
  assign torque_current_o = out_data.torque_current;
  assign shaft_speed_o    = out_data.shaft_speed;
  assign shaft_position_o = out_data.shaft_position;
  assign fault_o          = out_data.fault;

endmodule

`default_nettype wire

/* src/mfp_out_buf.sv */
// Result register plus one skid entry for the frame parser's output channel.
// Depends on mfp_pkg (result_t).
`default_nettype none

module mfp_out_buf (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire mfp_pkg::result_t push_data_i,
  output logic                 full_o,
  output logic                 valid_o,
  input  wire logic            stall_i,
  output mfp_pkg::result_t     data_o
);
  import mfp_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop = out_valid_q & ~stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      // upstream is held off while the skid entry is occupied
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_d       = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o  = skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule

`default_nettype wire

/* src/mfp_checker.sv */
// Port-level checks for motor_feedback_frame_parser_unit, bound to the top.
// Depends on mfp_pkg (status codes).
`default_nettype none

module mfp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        frame_end_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  status_o,
  input wire logic [7:0]  drive_mode_o,
  input wire logic [15:0] torque_current_o,
  input wire logic [15:0] shaft_speed_o,
  input wire logic [15:0] shaft_position_o,
  input wire logic [7:0]  fault_o
);
  import mfp_pkg::*;

  // a fresh result only follows an accepted last beat
  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && frame_end_i))
    else $error("result without a preceding last beat");

  // backpressure upstream only while a result is stuck downstream
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  a_stall_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall rose without an output stall");

  a_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |->
      (drive_mode_o == '0 && torque_current_o == '0 && shaft_speed_o == '0 &&
       shaft_position_o == '0 && fault_o == '0))
    else $error("nonzero fields on a failed frame");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o)))
    else $error("stalled result changed");

endmodule

bind motor_feedback_frame_parser_unit mfp_checker u_mfp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .frame_end_i      (frame_end_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .status_o         (status_o),
  .drive_mode_o     (drive_mode_o),
  .torque_current_o (torque_current_o),
  .shaft_speed_o    (shaft_speed_o),
  .shaft_position_o (shaft_position_o),
  .fault_o          (fault_o)
);

`default_nettype wire

/* sim/motor_feedback_frame_parser_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for motor_feedback_frame_parser_unit: sends byte frames with
// random gaps and output stalls, predicts each frame's result and checks it field by field.
// Depends on mfp_pkg and the parser RTL.

module motor_feedback_frame_parser_unit_test;
  import mfp_pkg::*;

  localparam int unsigned CycleLimit    = 200_000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned MaxPrinted    = 40;

  typedef logic [7:0] frame_q_t[$];

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               expected_id_we_i;
  logic [7:0]         expected_id_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         rx_byte_i;
  logic               frame_end_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic [7:0]         drive_mode_o;
  logic signed [15:0] torque_current_o;
  logic signed [15:0] shaft_speed_o;
  logic [15:0]        shaft_position_o;
  logic [7:0]         fault_o;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_left;
  int unsigned cycle_count;
  int unsigned error_count;

  // frame tracking copy of the parser state
  logic [3:0] rx_count;
  logic [7:0] rx_crc;
  logic [7:0] rx_id;
  logic [7:0] rx_crc_byte;
  logic [7:0] rx_body [8];
  logic [7:0] id_cfg;
  result_t    pending_results[$];

  always #5 clk_i = ~clk_i;

  motor_feedback_frame_parser_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .expected_id_we_i (expected_id_we_i),
    .expected_id_i    (expected_id_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .frame_end_i      (frame_end_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .drive_mode_o     (drive_mode_o),
    .torque_current_o (torque_current_o),
    .shaft_speed_o    (shaft_speed_o),
    .shaft_position_o (shaft_position_o),
    .fault_o          (fault_o)
  );

  // bitwise form of reflected CRC-8/Maxim: one data bit per shift
  function automatic logic [7:0] crc8_maxim(input logic [7:0] acc, input logic [7:0] d);
    logic [7:0] c;
    logic       mix;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      mix = c[0] ^ d[i];
      c = c >> 1;
      if (mix) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  function automatic void track_byte(input logic [7:0] b, input logic last);
    logic [3:0] pos;
    result_t    r;
    pos = rx_count;
    if (pos == 4'd0) begin
      rx_id = b;
    end else if (pos <= 4'd8) begin
      rx_body[3'(pos - 4'd1)] = b;
    end else if (pos == CrcSpan) begin
      rx_crc_byte = b;
    end
    if (pos < CrcSpan) begin
      rx_crc = crc8_maxim(rx_crc, b);
    end
    if (pos < CountSat) begin
      rx_count = pos + 4'd1;
    end
    if (last) begin
      r = '0;
      if (rx_count != FrameLen) begin
        r.status = ST_BAD_LEN;
      end else if (rx_id != id_cfg) begin
        r.status = ST_ID_MISMATCH;
      end else if (rx_crc != rx_crc_byte) begin
        r.status = ST_CRC_MISMATCH;
      end else begin
        r.status         = ST_OK;
        r.drive_mode     = rx_body[0];
        r.torque_current = {rx_body[1], rx_body[2]};
        r.shaft_speed    = {rx_body[3], rx_body[4]};
        r.shaft_position = {rx_body[5], rx_body[6]};
        r.fault          = rx_body[7];
      end
      pending_results = {pending_results, r};
      rx_count = '0;
      rx_crc   = CrcInit;
    end
  endfunction

  task automatic report_error(input string msg);
    if (error_count < MaxPrinted) begin
      $display("%0t ERROR %s", $time, msg);
    end
    error_count++;
  endtask

  task automatic check_result();
    result_t want;
    if (pending_results.size() == 0) begin
      report_error($sformatf("unexpected result beat, status %0d", status_o));
      return;
    end
    want = pending_results.pop_front();
    if (status_o !== want.status)
      report_error($sformatf("status got %0d want %0d", status_o, want.status));
    if (drive_mode_o !== want.drive_mode)
      report_error($sformatf("drive_mode got %h want %h", drive_mode_o, want.drive_mode));
    if (torque_current_o !== want.torque_current)
      report_error($sformatf("torque_current got %0d want %0d",
                             torque_current_o, want.torque_current));
    if (shaft_speed_o !== want.shaft_speed)
      report_error($sformatf("shaft_speed got %0d want %0d", shaft_speed_o, want.shaft_speed));
    if (shaft_position_o !== want.shaft_position)
      report_error($sformatf("shaft_position got %h want %h",
                             shaft_position_o, want.shaft_position));
    if (fault_o !== want.fault)
      report_error($sformatf("fault got %h want %h", fault_o, want.fault));
  endtask

  // one process sees both channels, so prediction and check never race
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        track_byte(rx_byte_i, frame_end_i);
      end
      if (out_valid_o && !out_stall_i) begin
        check_result();
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= (hold_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("motor_feedback_frame_parser_unit_test: FAIL");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    rx_byte_i   <= b;
    frame_end_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic send_frame(input frame_q_t f);
    foreach (f[i]) begin
      send_byte(f[i], i == f.size() - 1);
    end
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_expected_id(input logic [7:0] v);
    wait_for_results();
    expected_id_we_i <= 1'b1;
    expected_id_i    <= v;
    @(negedge clk_i);
    expected_id_we_i <= 1'b0;
    id_cfg = v;
  endtask

  task automatic set_idle(input int unsigned s, input int unsigned r);
    send_idle_pct = s;
    recv_idle_pct = r;
  endtask

  // append the CRC of bytes 0..8
  function automatic frame_q_t sealed(input frame_q_t f);
    logic [7:0] c;
    frame_q_t   g;
    c = CrcInit;
    g = f;
    for (int i = 0; i < 9; i++) begin
      c = crc8_maxim(c, f[i]);
    end
    g = {g, c};
    return g;
  endfunction

  function automatic frame_q_t good_frame(input logic [7:0] id);
    frame_q_t f;
    f = {id};
    repeat (8) f = {f, 8'($urandom)};
    return sealed(f);
  endfunction

  function automatic frame_q_t random_frame();
    frame_q_t    f;
    int unsigned kind;
    int unsigned len;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      f = good_frame(id_cfg);
    end else if (kind < 70) begin
      f = good_frame(id_cfg ^ 8'($urandom_range(1, 255)));
    end else if (kind < 80) begin
      f = good_frame(id_cfg);
      f[9] = f[9] ^ 8'($urandom_range(1, 255));
    end else if (kind < 90) begin
      // well-formed start, cut short, run long or left at ten bytes
      f = good_frame(id_cfg);
      len = $urandom_range(1, 14);
      while (f.size() > len) void'(f.pop_back());
      while (f.size() < len) f = {f, 8'($urandom)};
    end else begin
      len = $urandom_range(1, 15);
      repeat (len) f = {f, 8'($urandom)};
    end
    return f;
  endfunction

  task automatic run_random(input int unsigned n_bytes);
    int unsigned sent;
    frame_q_t    f;
    sent = 0;
    while (sent < n_bytes) begin
      f = random_frame();
      send_frame(f);
      sent += f.size();
    end
  endtask

  task automatic test_directed_frames();
    frame_q_t f;
    // ID 0 matches the reset value; min current, max speed, max position
    f = {8'h00, 8'hFF, 8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h00};
    send_frame(sealed(f));
    // single byte with a wrong ID: length wins over ID
    f = {8'hA5};
    send_frame(f);
    // good first ten bytes, then extras that only push the count to saturation
    f = good_frame(8'h00);
    f = {f, 8'h5A, 8'hC3, 8'h3C};
    send_frame(f);
  endtask

  task automatic test_id_register();
    logic [7:0] ids [4];
    ids = '{8'hFF, 8'h00, 8'($urandom), 8'h5A};
    foreach (ids[i]) begin
      write_expected_id(ids[i]);
      send_frame(good_frame(ids[i]));
      send_frame(good_frame(~ids[i]));
    end
  endtask

  task automatic test_backpressure();
    set_idle(0, 0);
    wait_for_results();
    @(posedge clk_i);
    hold_left = HoldOffCycles;
    @(negedge clk_i);
    // the output fills while the receiver holds off and input stalls
    repeat (12) send_frame(random_frame());
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    set_idle(13, 63);
    run_random(110);
    write_expected_id(8'($urandom));
    set_idle(63, 13);
    run_random(110);
    write_expected_id(8'($urandom));
    set_idle(0, 0);
    run_random(110);
  endtask

  initial begin
    rst_ni           = 1'b0;
    expected_id_we_i = 1'b0;
    expected_id_i    = 8'h00;
    in_valid_i       = 1'b0;
    rx_byte_i        = 8'h00;
    frame_end_i      = 1'b0;
    hold_left        = 0;
    cycle_count      = 0;
    error_count      = 0;
    rx_count         = '0;
    rx_crc           = CrcInit;
    rx_id            = '0;
    rx_crc_byte      = '0;
    id_cfg           = '0;
    foreach (rx_body[i]) rx_body[i] = '0;
    set_idle(13, 63);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_frames();
    test_id_register();
    test_backpressure();
    test_random_traffic();

    wait_for_results();
    repeat (10) @(negedge clk_i);
    if (pending_results.size() != 0) begin
      report_error($sformatf("%0d results never arrived", pending_results.size()));
    end
    if (error_count == 0) begin
      $display("motor_feedback_frame_parser_unit_test: PASS");
    end else begin
      $display("motor_feedback_frame_parser_unit_test: FAIL");
    end
    $finish;
  end

endmodule
